@@ rtl/symbolic_mode_parser_unit_assert.svh @@
// assertion macros shared by the mode parser rtl files
`ifndef SYMBOLIC_MODE_PARSER_UNIT_ASSERT_SVH
`define SYMBOLIC_MODE_PARSER_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SMP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mode parser check failed");

// consequent checked in the cycle after the antecedent
`define SMP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mode parser check failed");

`endif

@@ rtl/smp_pkg.sv @@
// types and constants of the symbolic mode parser
`default_nettype none

package smp_pkg;

    localparam int unsigned MODE_W = 9;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // permission bit groups
    localparam logic [MODE_W-1:0] M_USER  = 9'o700;
    localparam logic [MODE_W-1:0] M_GROUP = 9'o070;
    localparam logic [MODE_W-1:0] M_OTHER = 9'o007;
    localparam logic [MODE_W-1:0] M_ALL   = 9'o777;
    localparam logic [MODE_W-1:0] M_READ  = 9'o444;
    localparam logic [MODE_W-1:0] M_WRITE = 9'o222;
    localparam logic [MODE_W-1:0] M_EXEC  = 9'o111;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CREATION_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IS_DIRECTORY  = 2'd2;
    localparam logic [MODE_W-1:0] RST_INITIAL_MODE  = 9'o777;
    localparam logic [MODE_W-1:0] RST_CREATION_MASK = 9'o022;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
    localparam logic [CHAR_W-1:0] CH_8     = 8'h38;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3d;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
    localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
    localparam logic [CHAR_W-1:0] CH_O     = 8'h6f;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_XCAP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_L     = 8'h6c;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
    localparam logic [CHAR_W-1:0] CH_T     = 8'h74;

    typedef enum logic [6:0] {
        PH_START      = 7'b0000001,
        PH_OCTAL      = 7'b0000010,
        PH_WHO        = 7'b0000100,
        PH_PERM_FIRST = 7'b0001000,
        PH_PERM       = 7'b0010000,
        PH_AFTER_COPY = 7'b0100000,
        PH_ERROR      = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_SET  = 2'd3
    } op_t;

    typedef struct packed {
        logic [MODE_W-1:0] initial_mode;
        logic [MODE_W-1:0] creation_mask;
        logic              is_directory;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [MODE_W-1:0] final_mode;
        logic              mode_error;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/smp_parse_core.sv @@
// parse state registers and per-character next-state logic
`default_nettype none
`include "symbolic_mode_parser_unit_assert.svh"

module smp_parse_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         fire,
    input  wire logic [smp_pkg::CHAR_W-1:0]   ch,
    input  wire smp_pkg::cfg_t                cfg,
    output smp_pkg::res_t                     res
);

    smp_pkg::phase_t             phase_reg, phase_next, eff_phase;
    logic [smp_pkg::MODE_W-1:0]  wm_reg, wm_next, wm_cur;
    logic [smp_pkg::MODE_W-1:0]  who_reg, who_next, who_cur;
    logic [smp_pkg::MODE_W-1:0]  extra_reg, extra_next, extra_cur;
    smp_pkg::op_t                pop_reg, pop_next, pop_cur;
    logic [smp_pkg::MODE_W-1:0]  pbits_reg, pbits_next, pbits_cur;
    logic [smp_pkg::MODE_W-1:0]  committed, who_dflt, b_masked;
    logic [2:0]                  copy_field;
    logic                        is_digit, is_89, in_perm, x_grant;
    smp_pkg::op_t                op_in;

    // operation character decode
    function automatic smp_pkg::op_t op_code(input logic [smp_pkg::CHAR_W-1:0] c);
        smp_pkg::op_t o;
        case (c)
            smp_pkg::CH_PLUS:  o = smp_pkg::OP_ADD;
            smp_pkg::CH_MINUS: o = smp_pkg::OP_SUB;
            smp_pkg::CH_EQUAL: o = smp_pkg::OP_SET;
            default:           o = smp_pkg::OP_NONE;
        endcase
        return o;
    endfunction

    // values seen by this character; the first character of a string starts fresh
    always_comb begin
        if (phase_reg == smp_pkg::PH_START) begin
            wm_cur    = cfg.initial_mode;
            who_cur   = '0;
            extra_cur = '0;
            pop_cur   = smp_pkg::OP_NONE;
            pbits_cur = '0;
        end else begin
            wm_cur    = wm_reg;
            who_cur   = who_reg;
            extra_cur = extra_reg;
            pop_cur   = pop_reg;
            pbits_cur = pbits_reg;
        end
        is_digit  = ch inside {[smp_pkg::CH_0:smp_pkg::CH_7]};
        is_89     = ch inside {smp_pkg::CH_8, smp_pkg::CH_9};
        eff_phase = (phase_reg == smp_pkg::PH_START) ? smp_pkg::PH_WHO : phase_reg;
        op_in     = op_code(ch);
        in_perm   = (phase_reg == smp_pkg::PH_PERM_FIRST) || (phase_reg == smp_pkg::PH_PERM) ||
                    (phase_reg == smp_pkg::PH_AFTER_COPY);
        x_grant   = cfg.is_directory || (|(cfg.initial_mode & smp_pkg::M_EXEC));
        who_dflt  = smp_pkg::M_ALL & ~cfg.creation_mask;
    end

    // apply the pending operation to the working mode
    always_comb begin
        b_masked = pbits_cur & who_cur;
        case (pop_cur)
            smp_pkg::OP_ADD: committed = wm_cur | b_masked;
            smp_pkg::OP_SUB: committed = wm_cur & ~b_masked;
            smp_pkg::OP_SET: committed = (wm_cur & ~(who_cur | extra_cur)) | b_masked;
            default:         committed = wm_cur;
        endcase
    end

    // copy letter source field
    always_comb begin
        case (ch)
            smp_pkg::CH_U: copy_field = wm_cur[8:6];
            smp_pkg::CH_G: copy_field = wm_cur[5:3];
            default:       copy_field = wm_cur[2:0];
        endcase
    end

    // next state and result for one character
    always_comb begin
        phase_next = phase_reg;
        wm_next    = wm_reg;
        who_next   = who_reg;
        extra_next = extra_reg;
        pop_next   = pop_reg;
        pbits_next = pbits_reg;
        res.valid      = 1'b0;
        res.final_mode = wm_cur;
        res.mode_error = 1'b0;
        if (fire) begin
            wm_next    = wm_cur;
            who_next   = who_cur;
            extra_next = extra_cur;
            pop_next   = pop_cur;
            pbits_next = pbits_cur;
            if (ch == smp_pkg::CH_NUL) begin
                // end of string: report and rearm
                res.valid = 1'b1;
                if (phase_reg == smp_pkg::PH_ERROR) begin
                    res.final_mode = cfg.initial_mode;
                    res.mode_error = 1'b1;
                end else if (in_perm) begin
                    res.final_mode = committed;
                end
                phase_next = smp_pkg::PH_START;
                wm_next    = cfg.initial_mode;
                who_next   = '0;
                extra_next = '0;
                pop_next   = smp_pkg::OP_NONE;
                pbits_next = '0;
            end else if (phase_reg == smp_pkg::PH_START && is_digit) begin
                wm_next    = {6'b0, ch[2:0]};
                phase_next = smp_pkg::PH_OCTAL;
            end else if (phase_reg == smp_pkg::PH_START && is_89) begin
                phase_next = smp_pkg::PH_ERROR;
            end else begin
                case (eff_phase)
                    smp_pkg::PH_OCTAL: begin
                        if (is_digit) begin
                            wm_next = {wm_cur[5:0], ch[2:0]};
                        end else begin
                            phase_next = smp_pkg::PH_ERROR;
                        end
                    end
                    smp_pkg::PH_WHO: begin
                        phase_next = smp_pkg::PH_WHO;
                        case (ch)
                            smp_pkg::CH_U: who_next = who_cur | smp_pkg::M_USER;
                            smp_pkg::CH_G: who_next = who_cur | smp_pkg::M_GROUP;
                            smp_pkg::CH_O: who_next = who_cur | smp_pkg::M_OTHER;
                            smp_pkg::CH_A: who_next = who_cur | smp_pkg::M_ALL;
                            default: begin
                                // no who letters means everything outside the mask
                                if (who_cur == '0) begin
                                    who_next   = who_dflt;
                                    extra_next = cfg.creation_mask;
                                end else begin
                                    extra_next = '0;
                                end
                                if (op_in != smp_pkg::OP_NONE) begin
                                    pop_next   = op_in;
                                    pbits_next = '0;
                                    phase_next = smp_pkg::PH_PERM_FIRST;
                                end else if (ch == smp_pkg::CH_COMMA) begin
                                    who_next   = '0;
                                    extra_next = '0;
                                end else begin
                                    phase_next = smp_pkg::PH_ERROR;
                                end
                            end
                        endcase
                    end
                    smp_pkg::PH_PERM_FIRST, smp_pkg::PH_PERM, smp_pkg::PH_AFTER_COPY: begin
                        if (eff_phase == smp_pkg::PH_PERM_FIRST &&
                            (ch inside {smp_pkg::CH_U, smp_pkg::CH_G, smp_pkg::CH_O})) begin
                            pbits_next = {copy_field, copy_field, copy_field};
                            phase_next = smp_pkg::PH_AFTER_COPY;
                        end else if (eff_phase != smp_pkg::PH_AFTER_COPY &&
                                     (ch inside {smp_pkg::CH_R, smp_pkg::CH_W, smp_pkg::CH_X,
                                                 smp_pkg::CH_XCAP, smp_pkg::CH_L,
                                                 smp_pkg::CH_S, smp_pkg::CH_T})) begin
                            case (ch)
                                smp_pkg::CH_R: pbits_next = pbits_cur | smp_pkg::M_READ;
                                smp_pkg::CH_W: pbits_next = pbits_cur | smp_pkg::M_WRITE;
                                smp_pkg::CH_X: pbits_next = pbits_cur | smp_pkg::M_EXEC;
                                smp_pkg::CH_XCAP: begin
                                    if (x_grant) begin
                                        pbits_next = pbits_cur | smp_pkg::M_EXEC;
                                    end
                                end
                                default: pbits_next = pbits_cur;
                            endcase
                            phase_next = smp_pkg::PH_PERM;
                        end else if (op_in != smp_pkg::OP_NONE) begin
                            wm_next    = committed;
                            pop_next   = op_in;
                            pbits_next = '0;
                            phase_next = smp_pkg::PH_PERM_FIRST;
                        end else if (ch == smp_pkg::CH_COMMA) begin
                            wm_next    = committed;
                            pop_next   = smp_pkg::OP_NONE;
                            pbits_next = '0;
                            who_next   = '0;
                            extra_next = '0;
                            phase_next = smp_pkg::PH_WHO;
                        end else begin
                            phase_next = smp_pkg::PH_ERROR;
                        end
                    end
                    default: begin
                        // error phase swallows everything up to the terminator
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= smp_pkg::PH_START;
            wm_reg    <= smp_pkg::RST_INITIAL_MODE;
            who_reg   <= '0;
            extra_reg <= '0;
            pop_reg   <= smp_pkg::OP_NONE;
            pbits_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            wm_reg    <= wm_next;
            who_reg   <= who_next;
            extra_reg <= extra_next;
            pop_reg   <= pop_next;
            pbits_reg <= pbits_next;
        end
    end

    // a terminator always rearms the parser
    `SMP_ASSERT_NEXT(a_term_rearms, aclk, aresetn, fire && ch == smp_pkg::CH_NUL, phase_reg == smp_pkg::PH_START)
    // the error phase is sticky until the terminator
    `SMP_ASSERT_NEXT(a_error_sticky, aclk, aresetn, fire && ch != smp_pkg::CH_NUL && phase_reg == smp_pkg::PH_ERROR, phase_reg == smp_pkg::PH_ERROR)

endmodule

`default_nettype wire

@@ rtl/symbolic_mode_parser_unit.sv @@
// top level of the symbolic mode parser: config registers, input and result registers
// m_valid rises from the result register once a terminator held in the input register fires
// throughput: one character per cycle unless a result waits on m_ready; state updates once per registered character
// reset: aresetn synchronous active low; config returns to 0777, 0022, directory set
`default_nettype none
`include "symbolic_mode_parser_unit_assert.svh"

module symbolic_mode_parser_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [smp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [smp_pkg::MODE_W-1:0]      cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [smp_pkg::CHAR_W-1:0]      s_character,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [smp_pkg::MODE_W-1:0]           m_final_mode,
    output logic                                 m_mode_error
);

    smp_pkg::cfg_t                 cfg_reg;
    smp_pkg::res_t                 res;
    logic                          in_valid_reg;
    logic [smp_pkg::CHAR_W-1:0]    in_char_reg;
    logic                          out_valid_reg;
    logic [smp_pkg::MODE_W-1:0]    out_mode_reg;
    logic                          out_error_reg;
    logic                          advance, fire;

    // pipeline moves when the result slot is free or being emptied
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_mode  <= smp_pkg::RST_INITIAL_MODE;
            cfg_reg.creation_mask <= smp_pkg::RST_CREATION_MASK;
            cfg_reg.is_directory  <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                smp_pkg::CFG_INITIAL_MODE:  cfg_reg.initial_mode  <= cfg_wdata;
                smp_pkg::CFG_CREATION_MASK: cfg_reg.creation_mask <= cfg_wdata;
                smp_pkg::CFG_IS_DIRECTORY:  cfg_reg.is_directory  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_character;
        end
    end

    // parse engine
    smp_parse_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .ch      (in_char_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_mode_reg  <= res.final_mode;
            out_error_reg <= res.mode_error;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_final_mode = out_mode_reg;
    assign m_mode_error = out_error_reg;

    // a held character stays put while the result slot is blocked
    `SMP_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_char_reg))
    // only a terminator transaction can fill the result slot
    `SMP_ASSERT_NEXT(a_out_only_on_term, aclk, aresetn, advance && !(in_valid_reg && in_char_reg == smp_pkg::CH_NUL), !out_valid_reg)

endmodule

`default_nettype wire
